>>> sv/ufr_pkg.sv
// Types, constants and the CRC-8 step shared by the frame receiver files.
package ufr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] REG_START_BYTE = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [RegIdxW-1:0] REG_CRC_POLY   = 2'd2;

  localparam logic [ByteW-1:0] START_BYTE_RST = 8'hA5;
  localparam logic [ByteW-1:0] MAX_LENGTH_RST = 8'd60;
  localparam logic [ByteW-1:0] CRC_POLY_RST   = 8'h31;

  localparam logic [ByteW-1:0] RESPONSE_BASE  = 8'h80;
  localparam logic [ByteW-1:0] BOOT_ACK_CMD   = 8'h90;
  localparam logic [ByteW-1:0] FABRIC_ACK_CMD = 8'h91;

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [StatusW-1:0] STATUS_LEN_ERR = 2'd2;

  localparam logic [ClassW-1:0] CLASS_NONE       = 3'd0;
  localparam logic [ClassW-1:0] CLASS_COMMAND    = 3'd1;
  localparam logic [ClassW-1:0] CLASS_BOOT_ACK   = 3'd2;
  localparam logic [ClassW-1:0] CLASS_FABRIC_ACK = 3'd3;
  localparam logic [ClassW-1:0] CLASS_RESPONSE   = 3'd4;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [StatusW-1:0] frame_status;
    logic [ByteW-1:0]   command_code;
    logic [ByteW-1:0]   payload_length;
    logic [ByteW-1:0]   received_check;
    logic [ByteW-1:0]   computed_check;
    logic [ClassW-1:0]  frame_class;
  } res_item_t;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] acc,
                                                 input logic [ByteW-1:0] data,
                                                 input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] c;
    c = acc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/ufr_if.sv
// Valid/ready channels for received bytes and frame results.
interface ufr_rx_if import ufr_pkg::*;;
  logic     valid;
  logic     ready;
  rx_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ufr_res_if import ufr_pkg::*;;
  logic      valid;
  logic      ready;
  res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/uart_frame_receiver_crc8.sv
// Length-prefixed frame receiver with incremental CRC-8 check.
//
// Takes one received byte per clock on rx_i, unless a waiting result is stalled, and
// returns at most one result per frame on res_o. When a byte is taken, the frame state
// and the CRC-8 step (eight unrolled shift/xor steps) update in that cycle and any
// result lands in the output register in the cycle after the transfer. A waiting
// result blocks input only while res_o is stalled; when it is taken in the same
// cycle a new byte is accepted. Configuration writes are taken at any edge and
// should be made while no frame is in flight.
module uart_frame_receiver_crc8 import ufr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  ufr_rx_if.sink             rx_i,
  ufr_res_if.source          res_o
);

  logic [ByteW-1:0] start_byte_q, max_length_q, crc_poly_q;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] bytes_left_q, bytes_left_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] length_q, length_d;
  logic             first_q, first_d;
  logic             live_q;
  logic             res_valid_q, res_valid_d;
  res_item_t        res_q, res_d;
  logic             res_hit;
  logic             rx_fire;
  logic [ByteW-1:0] b;

  assign b          = rx_i.payload.rx_byte;
  assign rx_i.ready = live_q & (~res_valid_q | res_o.ready);
  assign rx_fire    = rx_i.valid & rx_i.ready;

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      max_length_q <= MAX_LENGTH_RST;
      crc_poly_q   <= CRC_POLY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_BYTE: start_byte_q <= cfg_wdata_i;
        REG_MAX_LENGTH: max_length_q <= cfg_wdata_i;
        REG_CRC_POLY:   crc_poly_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    crc_d        = crc_q;
    cmd_d        = cmd_q;
    length_d     = length_q;
    first_d      = first_q;
    res_hit      = 1'b0;
    res_d        = '0;
    if (rx_fire) begin
      case (phase_q)
        PH_HUNT: begin
          if (b == start_byte_q) phase_d = PH_LEN;
        end
        PH_LEN: begin
          if ((b == '0) || (b > max_length_q)) begin
            phase_d            = PH_HUNT;
            res_hit            = 1'b1;
            res_d.frame_status = STATUS_LEN_ERR;
          end else begin
            length_d     = b;
            bytes_left_d = b;
            crc_d        = crc8_step('0, b, crc_poly_q);
            first_d      = 1'b1;
            phase_d      = PH_BODY;
          end
        end
        PH_BODY: begin
          if (first_q) begin
            cmd_d   = b;
            first_d = 1'b0;
          end
          crc_d        = crc8_step(crc_q, b, crc_poly_q);
          bytes_left_d = bytes_left_q - 8'd1;
          if (bytes_left_d == '0) phase_d = PH_CRC;
        end
        PH_CRC: begin
          res_hit              = 1'b1;
          res_d.command_code   = cmd_q;
          res_d.payload_length = length_q - 8'd1;
          res_d.received_check = b;
          res_d.computed_check = crc_q;
          if (crc_q == b) begin
            res_d.frame_status = STATUS_OK;
            if (cmd_q < RESPONSE_BASE) begin
              res_d.frame_class = CLASS_COMMAND;
            end else if (cmd_q == BOOT_ACK_CMD) begin
              res_d.frame_class = CLASS_BOOT_ACK;
            end else if (cmd_q == FABRIC_ACK_CMD) begin
              res_d.frame_class = CLASS_FABRIC_ACK;
            end else begin
              res_d.frame_class = CLASS_RESPONSE;
            end
          end else begin
            res_d.frame_status = STATUS_CRC_ERR;
            res_d.frame_class  = CLASS_NONE;
          end
          phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (rx_fire && res_hit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bytes_left_q <= '0;
      crc_q        <= '0;
      cmd_q        <= '0;
      length_q     <= '0;
      first_q      <= 1'b0;
      live_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
      cmd_q        <= cmd_d;
      length_q     <= length_d;
      first_q      <= first_d;
      live_q       <= 1'b1;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && res_hit) res_q <= res_d;
  end

endmodule

>>> sv/ufr_checker.sv
// Port-level checks for the frame receiver, bound into uart_frame_receiver_crc8.
module ufr_checker import ufr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input res_item_t out_res_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_i))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_res_i.frame_status == STATUS_OK ||
                    out_res_i.frame_status == STATUS_CRC_ERR ||
                    out_res_i.frame_status == STATUS_LEN_ERR)
    else $error("unknown frame status");

  a_len_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.frame_status == STATUS_LEN_ERR |->
      out_res_i.command_code == '0 && out_res_i.payload_length == '0 &&
      out_res_i.received_check == '0 && out_res_i.computed_check == '0 &&
      out_res_i.frame_class == CLASS_NONE)
    else $error("length error result carries data");

  a_crc_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.frame_status != STATUS_LEN_ERR |->
      ((out_res_i.received_check == out_res_i.computed_check) ==
       (out_res_i.frame_status == STATUS_OK)) &&
      ((out_res_i.frame_class == CLASS_NONE) ==
       (out_res_i.frame_status == STATUS_CRC_ERR)))
    else $error("status or class disagrees with check bytes");

  a_res_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !($past(out_valid_i) && !$past(out_ready_i)) |->
      $past(in_valid_i && in_ready_i))
    else $error("result without a byte transfer");

endmodule

bind uart_frame_receiver_crc8 ufr_checker u_ufr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_i.valid),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_res_i   (res_o.payload)
);

>>> dv/tb.sv
// Self-checking testbench for the CRC-8 frame receiver: frame stimulus, prediction and checks.
module tb import ufr_pkg::*;;

  localparam logic [RegIdxW-1:0] REG_SPARE = 2'd3;
  localparam int unsigned QuietLimit = 500;

  class frame_scoreboard;
    logic [ByteW-1:0] start_val;
    logic [ByteW-1:0] max_len;
    logic [ByteW-1:0] poly;
    phase_e           phase;
    logic [ByteW-1:0] left;
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] len;
    bit               first;
    res_item_t        frames_due[$];
    int unsigned      errors;
    int unsigned      n_bytes;
    int unsigned      n_ok;
    int unsigned      n_crc;
    int unsigned      n_len;

    function new();
      start_val = START_BYTE_RST;
      max_len   = MAX_LENGTH_RST;
      poly      = CRC_POLY_RST;
      phase     = PH_HUNT;
      left      = '0;
      crc       = '0;
      cmd       = '0;
      len       = '0;
      first     = 1'b0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        REG_START_BYTE: start_val = val;
        REG_MAX_LENGTH: max_len = val;
        REG_CRC_POLY:   poly = val;
        default: ;
      endcase
    endfunction

    // bit-serial form: feed data MSB first into the top of the register
    function logic [ByteW-1:0] crc_byte(logic [ByteW-1:0] acc, logic [ByteW-1:0] d);
      logic [ByteW-1:0] r;
      logic fb;
      r = acc;
      for (int i = ByteW - 1; i >= 0; i--) begin
        fb = r[ByteW-1] ^ d[i];
        r  = {r[ByteW-2:0], 1'b0};
        if (fb) begin
          r = r ^ poly;
        end
      end
      return r;
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      res_item_t r;
      r = '0;
      if (phase != PH_HUNT || b == start_val) begin
        n_bytes++;
      end
      case (phase)
        PH_HUNT: begin
          if (b == start_val) begin
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == 8'd0 || b > max_len) begin
            r.frame_status = STATUS_LEN_ERR;
            frames_due.push_back(r);
            n_len++;
            phase = PH_HUNT;
          end else begin
            len   = b;
            left  = b;
            crc   = crc_byte(8'h00, b);
            first = 1'b1;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (first) begin
            cmd   = b;
            first = 1'b0;
          end
          crc  = crc_byte(crc, b);
          left = left - 8'd1;
          if (left == 8'd0) begin
            phase = PH_CRC;
          end
        end
        default: begin
          r.command_code   = cmd;
          r.payload_length = len - 8'd1;
          r.received_check = b;
          r.computed_check = crc;
          if (crc == b) begin
            r.frame_status = STATUS_OK;
            if (cmd < RESPONSE_BASE) begin
              r.frame_class = CLASS_COMMAND;
            end else if (cmd == BOOT_ACK_CMD) begin
              r.frame_class = CLASS_BOOT_ACK;
            end else if (cmd == FABRIC_ACK_CMD) begin
              r.frame_class = CLASS_FABRIC_ACK;
            end else begin
              r.frame_class = CLASS_RESPONSE;
            end
            n_ok++;
          end else begin
            r.frame_status = STATUS_CRC_ERR;
            r.frame_class  = CLASS_NONE;
            n_crc++;
          end
          frames_due.push_back(r);
          phase = PH_HUNT;
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(res_item_t got);
      res_item_t want;
      if (frames_due.size() == 0) begin
        $error("result with no frame outstanding: %p", got);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      cmp_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
      cmp_field("command_code", want.command_code, got.command_code);
      cmp_field("payload_length", want.payload_length, got.payload_length);
      cmp_field("received_check", want.received_check, got.received_check);
      cmp_field("computed_check", want.computed_check, got.computed_check);
      cmp_field("frame_class", 8'(want.frame_class), 8'(got.frame_class));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_wdata_i;

  ufr_rx_if  rx_if ();
  ufr_res_if res_if ();

  frame_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned n_settings;

  uart_frame_receiver_crc8 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.payload.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_byte(b);
  endtask

  task automatic send_frame(input int unsigned n, input logic [ByteW-1:0] cmd,
                            input bit spoil);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] b;
    push_byte(sb.start_val);
    push_byte(8'(n));
    acc = sb.crc_byte(sb.crc_byte(8'h00, 8'(n)), cmd);
    push_byte(cmd);
    for (int unsigned i = 1; i < n; i++) begin
      b   = 8'($urandom);
      acc = sb.crc_byte(acc, b);
      push_byte(b);
    end
    if (spoil) begin
      acc = acc ^ 8'(1 << $urandom_range(0, 7));
    end
    push_byte(acc);
  endtask

  task automatic set_regs(input logic [ByteW-1:0] start_v, input logic [ByteW-1:0] len_v,
                          input logic [ByteW-1:0] poly_v, input bit poke_spare);
    logic [RegIdxW-1:0] idx[4];
    logic [ByteW-1:0]   val[4];
    idx = '{REG_START_BYTE, REG_MAX_LENGTH, REG_CRC_POLY, REG_SPARE};
    val = '{start_v, len_v, poly_v, 8'($urandom)};
    // close any open frame so the new settings start from hunting
    while (sb.phase != PH_HUNT) begin
      push_byte(sb.phase == PH_LEN ? 8'h00 : 8'($urandom));
    end
    rx_if.valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    for (int i = 0; i < (poke_spare ? 4 : 3); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[2'(i)];
      cfg_wdata_i <= val[2'(i)];
      @(posedge clk_i);
      sb.set_reg(idx[2'(i)], val[2'(i)]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned stop;
    int unsigned pick;
    int unsigned n;
    int unsigned cap;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] cmd;
    stop = sb.n_bytes + target;
    while (sb.n_bytes < stop) begin
      pick = $urandom_range(0, 99);
      if (sb.max_len == 8'd0 || pick < 8) begin
        push_byte(sb.start_val);
        if (sb.max_len == 8'd0) begin
          push_byte(8'($urandom));
        end else if (sb.max_len == 8'd255 || $urandom_range(0, 1) == 0) begin
          push_byte(8'h00);
        end else begin
          push_byte(8'($urandom_range(int'(sb.max_len) + 1, 255)));
        end
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if (b == sb.start_val && $urandom_range(0, 3) != 0) begin
            b = b ^ 8'h01;
          end
          push_byte(b);
        end
      end else if (pick < 22 && sb.max_len >= 8'd2) begin
        // drop the frame part way through the body
        push_byte(sb.start_val);
        push_byte(8'($urandom_range(2, int'(sb.max_len))));
        push_byte(8'($urandom));
      end else begin
        cap = (sb.max_len < 8'd6) ? int'(sb.max_len) : 6;
        case ($urandom_range(0, 19))
          0:       n = $urandom_range(1, int'(sb.max_len));
          1:       n = int'(sb.max_len);
          default: n = $urandom_range(1, cap);
        endcase
        case ($urandom_range(0, 5))
          0:       cmd = BOOT_ACK_CMD;
          1:       cmd = FABRIC_ACK_CMD;
          2:       cmd = 8'($urandom_range(0, 127));
          default: cmd = 8'($urandom);
        endcase
        send_frame(n, cmd, pick < 32);
      end
    end
  endtask

  task automatic pick_pressure();
    int unsigned lvl[3];
    lvl = '{0, 5, 15};
    src_idle_pct  = lvl[2'($urandom_range(0, 2))];
    snk_stall_pct = lvl[2'($urandom_range(0, 2))];
  endtask

  // result sink: hold ready low in random bursts
  initial begin
    int unsigned hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_frame(res_if.payload);
      end
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
        hold = $urandom_range(1, 19) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transfer for %0d cycles, %0d results outstanding", QuietLimit,
             sb.frames_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_index_i           <= REG_START_BYTE;
    cfg_wdata_i           <= '0;
    rx_if.valid           <= 1'b0;
    rx_if.payload.rx_byte <= '0;
    src_idle_pct  = 10;
    snk_stall_pct = 10;
    n_settings    = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(8'h00);
    push_byte(START_BYTE_RST);
    push_byte(8'h00);
    push_byte(START_BYTE_RST);
    push_byte(MAX_LENGTH_RST + 8'd1);
    send_frame(1, BOOT_ACK_CMD, 1'b0);
    send_frame(2, START_BYTE_RST, 1'b0);
    send_frame(1, FABRIC_ACK_CMD, 1'b0);
    send_frame(1, 8'h7F, 1'b1);
    send_frame(1, 8'h00, 1'b0);
    run_phase(200);

    src_idle_pct  = 0;
    snk_stall_pct = 15;
    set_regs(8'h00, 8'd255, 8'h00, 1'b0);
    run_phase(210);

    src_idle_pct  = 15;
    snk_stall_pct = 0;
    set_regs(8'hFF, 8'd1, 8'hFF, 1'b0);
    run_phase(210);

    pick_pressure();
    set_regs(8'h7E, 8'd0, 8'h07, 1'b1);
    run_phase(60);

    repeat (4) begin
      pick_pressure();
      set_regs(8'($urandom), 8'($urandom_range(1, 40)), 8'($urandom),
               1'($urandom_range(0, 1)));
      run_phase(210);
    end

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_regs(START_BYTE_RST, MAX_LENGTH_RST, CRC_POLY_RST, 1'b0);
    run_phase(200);

    rx_if.valid <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("%0d frame bytes over %0d register settings", sb.n_bytes, n_settings);
    $display("frames: %0d good, %0d CRC mismatch, %0d bad length; %0d mismatches",
             sb.n_ok, sb.n_crc, sb.n_len, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
